// File: hw/rtl/sptt_pkg.sv
// sptt_pkg: shared types and constants for the sparse polynomial term table
// no dependencies
package sptt_pkg;

   localparam int unsigned CoefW = 32;
   localparam int unsigned ExpW = 6;
   localparam int unsigned ValW = 48;
   localparam logic signed [31:0] QMax32 = 32'sh7fffffff;
   localparam logic signed [31:0] QMin32 = 32'sh80000000;
   localparam logic signed [47:0] QMax48 = 48'sh7fffffffffff;
   localparam logic signed [47:0] QMin48 = 48'sh800000000000;
   localparam logic signed [31:0] QOne = 32'sh00010000;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_SCALE = 2'd2,
      OP_EVAL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_FULL = 2'd1,
      ST_SAT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_MERGE,
      S_APPEND,
      S_SCALE_RD,
      S_SCALE_MUL,
      S_SCALE_WR,
      S_EV_RD,
      S_EV_POW,
      S_EV_SQR,
      S_EV_TERM,
      S_EV_ACC,
      S_DONE
   } state_type;

   // request payload
   typedef struct packed {
      op_type operation;
      logic signed [CoefW-1:0] term_coefficient;
      logic [ExpW-1:0] term_exponent;
      logic signed [CoefW-1:0] point_or_factor;
   } req_payload_type;

   // response payload
   typedef struct packed {
      logic signed [ValW-1:0] poly_value;
      status_type status;
      logic [4:0] terms_used;
   } rsp_payload_type;

   // request to the shared multiplier: a * b, floor-shifted by 16
   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
   } mul_req_type;

   typedef struct packed {
      logic signed [47:0] wide;  // floor(a*b/2^16), fits 48 bits unclamped
      logic signed [31:0] sat32; // same clamped to 32 bits
      logic ovf32;
   } mul_rsp_type;

endpackage

// File: hw/rtl/sptt_if.sv
// sptt_if: valid/ready channel carrying a payload of any packed type
// no dependencies
interface sptt_if #(parameter type payload_type = logic);
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/sptt_mul.sv
// sptt_mul: registered signed 32x32 multiplier with floor shift and clamping
// depends on sptt_pkg
module sptt_mul (
   input  logic clock,
   input  sptt_pkg::mul_req_type req,
   output sptt_pkg::mul_rsp_type rsp
);
   logic signed [47:0] sh;
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   assign prod_in = 64'(req.a) * 64'(req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // |a*b| <= 2^62, so the shifted value always fits 48 bits
   assign sh = prod_ff[63:16];

   always_comb begin
      rsp.wide = sh;
      rsp.ovf32 = (sh > 48'(sptt_pkg::QMax32)) || (sh < 48'(sptt_pkg::QMin32));
      if (sh > 48'(sptt_pkg::QMax32)) begin
         rsp.sat32 = sptt_pkg::QMax32;
      end else if (sh < 48'(sptt_pkg::QMin32)) begin
         rsp.sat32 = sptt_pkg::QMin32;
      end else begin
         rsp.sat32 = sh[31:0];
      end
   end
endmodule

// File: hw/rtl/sparse_polynomial_term_table.sv
// sparse_polynomial_term_table: sequenced term table with one shared multiplier
// depends on sptt_pkg, sptt_if, sptt_mul
//
// Holds up to TERMS (exponent, Q16.16 coefficient) terms. A request is taken only
// while the block is idle and yields one response. Add/subtract walks the table
// one stored entry at a time (read, then compare and merge), then appends the term
// if no entry matched, and finishes. Scale walks each term on the shared
// multiplier (read, multiply, write back). Evaluate runs square-and-multiply on
// the same multiplier, up to eleven multiplies plus the coefficient product per
// term, after reading the term and loading its working set. The response is held
// in an output register, and the next request can be taken from the cycle after
// it has been delivered.
module sparse_polynomial_term_table #(
   parameter int unsigned TERMS = 16
) (
   input logic clock,
   input logic reset,
   sptt_if.sink req,
   sptt_if.source rsp
);
   localparam int unsigned IdxW = (TERMS > 1) ? $clog2(TERMS) : 1;
   localparam int unsigned CntW = $clog2(TERMS + 1);

   // request payload fields
   sptt_pkg::op_type req_op;
   logic signed [31:0] req_coef;
   logic [5:0] req_exp;
   logic signed [31:0] req_pf;
   assign req_op = sptt_pkg::op_type'(req.payload.operation);
   assign req_coef = req.payload.term_coefficient;
   assign req_exp = req.payload.term_exponent;
   assign req_pf = req.payload.point_or_factor;

   // term storage
   logic [5:0] exp_mem [TERMS];
   logic signed [31:0] coef_mem [TERMS];

   sptt_pkg::state_type state_ff, state_in;
   logic [CntW-1:0] total_ff, total_in;
   logic [CntW-1:0] idx_ff, idx_in;
   sptt_pkg::op_type op_ff, op_in;
   logic signed [31:0] coef_ff, coef_in;
   logic [5:0] exp_ff, exp_in;
   logic signed [31:0] pf_ff, pf_in;
   logic sat_ff, sat_in;
   logic full_ff, full_in;
   logic found_ff, found_in;
   // evaluate working registers
   logic signed [31:0] acc_ff, acc_in;    // power accumulator
   logic signed [31:0] base_ff, base_in;
   logic [5:0] e_ff, e_in;                // remaining exponent bits
   logic signed [31:0] tc_ff, tc_in;      // term coefficient
   logic signed [47:0] val_ff, val_in;
   logic rsp_valid_ff, rsp_valid_in;

   // memory read port, registered
   logic [IdxW-1:0] rd_idx;
   logic [5:0] rd_exp_ff;
   logic signed [31:0] rd_coef_ff;
   logic wr_en;
   logic [IdxW-1:0] wr_idx;
   logic [5:0] wr_exp;
   logic signed [31:0] wr_coef;
   logic wr_exp_en;

   sptt_pkg::mul_req_type mreq;
   sptt_pkg::mul_rsp_type mrsp;

   sptt_mul u_mul (.clock(clock), .req(mreq), .rsp(mrsp));

   always_ff @(posedge clock) begin
      rd_exp_ff <= exp_mem[rd_idx];
      rd_coef_ff <= coef_mem[rd_idx];
      if (wr_en) begin
         coef_mem[wr_idx] <= wr_coef;
         if (wr_exp_en) begin
            exp_mem[wr_idx] <= wr_exp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sptt_pkg::S_IDLE;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      op_ff <= op_in;
      coef_ff <= coef_in;
      exp_ff <= exp_in;
      pf_ff <= pf_in;
      sat_ff <= sat_in;
      full_ff <= full_in;
      found_ff <= found_in;
      acc_ff <= acc_in;
      base_ff <= base_in;
      e_ff <= e_in;
      tc_ff <= tc_in;
      val_ff <= val_in;
   end

   // 33-bit merge and 49-bit accumulate arithmetic
   logic signed [32:0] merge_sum;
   logic signed [31:0] merge_sat;
   logic merge_ovf;
   logic signed [47:0] acc_sum;
   logic acc_ovf;
   logic signed [48:0] acc_wide;

   always_comb begin
      if (op_ff == sptt_pkg::OP_ADD) begin
         merge_sum = 33'(rd_coef_ff) + 33'(coef_ff);
      end else begin
         merge_sum = 33'(rd_coef_ff) - 33'(coef_ff);
      end
      merge_ovf = (merge_sum > 33'(sptt_pkg::QMax32)) || (merge_sum < 33'(sptt_pkg::QMin32));
      if (merge_sum > 33'(sptt_pkg::QMax32)) begin
         merge_sat = sptt_pkg::QMax32;
      end else if (merge_sum < 33'(sptt_pkg::QMin32)) begin
         merge_sat = sptt_pkg::QMin32;
      end else begin
         merge_sat = merge_sum[31:0];
      end
      acc_wide = 49'(val_ff) + 49'(mrsp.wide);
      acc_ovf = (acc_wide > 49'(sptt_pkg::QMax48)) || (acc_wide < 49'(sptt_pkg::QMin48));
      if (acc_wide > 49'(sptt_pkg::QMax48)) begin
         acc_sum = sptt_pkg::QMax48;
      end else if (acc_wide < 49'(sptt_pkg::QMin48)) begin
         acc_sum = sptt_pkg::QMin48;
      end else begin
         acc_sum = acc_wide[47:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      idx_in = idx_ff;
      op_in = op_ff;
      coef_in = coef_ff;
      exp_in = exp_ff;
      pf_in = pf_ff;
      sat_in = sat_ff;
      full_in = full_ff;
      found_in = found_ff;
      acc_in = acc_ff;
      base_in = base_ff;
      e_in = e_ff;
      tc_in = tc_ff;
      val_in = val_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_idx = idx_ff[IdxW-1:0];
      wr_en = 1'b0;
      wr_exp_en = 1'b0;
      wr_idx = idx_ff[IdxW-1:0];
      wr_exp = exp_ff;
      wr_coef = coef_ff;
      mreq.a = acc_ff;
      mreq.b = base_ff;
      req.ready = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sptt_pkg::S_IDLE: begin
            req.ready = !rsp_valid_ff;
            if (req.valid && !rsp_valid_ff) begin
               op_in = req_op;
               coef_in = req_coef;
               exp_in = req_exp;
               pf_in = req_pf;
               sat_in = 1'b0;
               full_in = 1'b0;
               found_in = 1'b0;
               idx_in = '0;
               val_in = '0;
               case (req_op)
                  sptt_pkg::OP_ADD, sptt_pkg::OP_SUB: state_in = sptt_pkg::S_SEARCH;
                  sptt_pkg::OP_SCALE: state_in = sptt_pkg::S_SCALE_RD;
                  default: state_in = sptt_pkg::S_EV_RD;
               endcase
               // empty table: add/subtract appends at once, the rest is done
               if (total_ff == '0) begin
                  if (req_op == sptt_pkg::OP_ADD || req_op == sptt_pkg::OP_SUB) begin
                     state_in = sptt_pkg::S_APPEND;
                  end else begin
                     state_in = sptt_pkg::S_DONE;
                  end
               end
            end
         end
         // walk the table; read data lands next cycle in rd_*_ff
         sptt_pkg::S_SEARCH: begin
            state_in = sptt_pkg::S_MERGE;
         end
         sptt_pkg::S_MERGE: begin
            if (rd_exp_ff == exp_ff) begin
               found_in = 1'b1;
               wr_en = 1'b1;
               wr_coef = merge_sat;
               sat_in = sat_ff | merge_ovf;
            end
            if (idx_ff + 1'b1 >= total_ff) begin
               if (found_in) begin
                  state_in = sptt_pkg::S_DONE;
               end else begin
                  state_in = sptt_pkg::S_APPEND;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = sptt_pkg::S_SEARCH;
            end
         end
         sptt_pkg::S_APPEND: begin
            if (total_ff >= CntW'(TERMS)) begin
               full_in = 1'b1;
            end else begin
               wr_en = 1'b1;
               wr_exp_en = 1'b1;
               wr_idx = total_ff[IdxW-1:0];
               if (op_ff == sptt_pkg::OP_ADD) begin
                  wr_coef = coef_ff;
               end else if (coef_ff == sptt_pkg::QMin32) begin
                  // negating the most negative value saturates
                  wr_coef = sptt_pkg::QMax32;
                  sat_in = 1'b1;
               end else begin
                  wr_coef = -coef_ff;
               end
               total_in = total_ff + 1'b1;
            end
            state_in = sptt_pkg::S_DONE;
         end
         sptt_pkg::S_SCALE_RD: begin
            state_in = sptt_pkg::S_SCALE_MUL;
         end
         sptt_pkg::S_SCALE_MUL: begin
            mreq.a = rd_coef_ff;
            mreq.b = pf_ff;
            state_in = sptt_pkg::S_SCALE_WR;
         end
         sptt_pkg::S_SCALE_WR: begin
            wr_en = 1'b1;
            wr_coef = mrsp.sat32;
            sat_in = sat_ff | mrsp.ovf32;
            if (idx_ff + 1'b1 >= total_ff) begin
               state_in = sptt_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = sptt_pkg::S_SCALE_RD;
            end
         end
         // read the term; data is in rd_*_ff next cycle
         sptt_pkg::S_EV_RD: begin
            state_in = sptt_pkg::S_EV_POW;
         end
         sptt_pkg::S_EV_POW: begin
            // load the working set for this term
            tc_in = rd_coef_ff;
            e_in = rd_exp_ff;
            acc_in = sptt_pkg::QOne;
            base_in = pf_ff;
            state_in = sptt_pkg::S_EV_SQR;
         end
         // next multiply: tc*acc if e is 0, acc*base if low bit set, else square
         sptt_pkg::S_EV_SQR: begin
            if (e_ff == '0) begin
               mreq.a = tc_ff;
               mreq.b = acc_ff;
               state_in = sptt_pkg::S_EV_ACC;
            end else if (e_ff[0]) begin
               mreq.a = acc_ff;
               mreq.b = base_ff;
               state_in = sptt_pkg::S_EV_TERM;
            end else begin
               mreq.a = base_ff;
               mreq.b = base_ff;
               state_in = sptt_pkg::S_EV_TERM;
            end
         end
         // multiply result back
         sptt_pkg::S_EV_TERM: begin
            sat_in = sat_ff | mrsp.ovf32;
            if (e_ff[0]) begin
               acc_in = mrsp.sat32;
               e_in = {e_ff[5:1], 1'b0};
               // squaring only while higher bits remain
               if (e_ff[5:1] == '0) begin
                  e_in = '0;
               end
            end else begin
               base_in = mrsp.sat32;
               e_in = {1'b0, e_ff[5:1]};
            end
            state_in = sptt_pkg::S_EV_SQR;
         end
         sptt_pkg::S_EV_ACC: begin
            val_in = acc_sum;
            sat_in = sat_ff | acc_ovf;
            if (idx_ff + 1'b1 >= total_ff) begin
               state_in = sptt_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = sptt_pkg::S_EV_RD;
            end
         end
         sptt_pkg::S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = sptt_pkg::S_IDLE;
         end
         default: begin
            state_in = sptt_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload.poly_value = val_ff;
   assign rsp.payload.status = sptt_pkg::status_type'(full_ff ? sptt_pkg::ST_FULL
                             : (sat_ff ? sptt_pkg::ST_SAT : sptt_pkg::ST_OK));
   assign rsp.payload.terms_used = 5'(total_ff);
endmodule
